[src/ukt_pkg.sv]
// Types and constants shared by the unordered key table.
// Command and result words, operation and status codes, control states.
// No dependencies.
package ukt_pkg;

  localparam int unsigned KEY_BITS  = 16;
  localparam int unsigned DATA_BITS = 32;
  localparam int unsigned POS_BITS  = 4;
  localparam int unsigned CNT_BITS  = 5;

  typedef enum logic [1:0] {
    KIND_INSERT = 2'd0,
    KIND_REMOVE = 2'd1,
    KIND_SEARCH = 2'd2
  } ukt_kind_e;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_FULL      = 2'd1,
    STAT_NOT_FOUND = 2'd2
  } ukt_status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_MOVE
  } ukt_state_e;

  typedef struct packed {
    ukt_kind_e             kind;
    logic [KEY_BITS-1:0]   key;
    logic [DATA_BITS-1:0]  payload_in;
  } ukt_cmd_t;

  typedef struct packed {
    ukt_status_e           status;
    logic [POS_BITS-1:0]   position;
    logic [DATA_BITS-1:0]  payload_out;
    logic [CNT_BITS-1:0]   entry_count;
    logic                  is_empty;
    logic                  is_full;
  } ukt_res_t;

  typedef struct packed {
    logic [KEY_BITS-1:0]   key;
    logic [DATA_BITS-1:0]  data;
  } ukt_entry_t;

endpackage

[src/ukt_ram.sv]
// Generic single-port-write, single-port-read synchronous RAM.
// Read data is registered and appears in the cycle after the read request. No dependencies.
module ukt_ram #(
  parameter int unsigned WIDTH = 48,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[src/unordered_key_table.sv]
// Unordered key table: insert appends, search and remove scan from entry 0.
// Insert and unused codes: busy stays low. Search stays busy while it scans the entries;
// remove with a hit adds a move step (read last entry, write it over the hit).
// The scan reads one entry per cycle from the entry RAM.
// The result strobe comes the cycle after the last busy cycle; the receiver cannot stall.
// Reset empties the table (count cleared); RAM contents are left as they are.
module unordered_key_table #(
  parameter int unsigned DEPTH = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  ukt_pkg::ukt_cmd_t cmd_i,
  output logic              valid_o,
  output ukt_pkg::ukt_res_t result_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned EW = ukt_pkg::KEY_BITS + ukt_pkg::DATA_BITS;

  ukt_pkg::ukt_state_e state_q, state_d;
  logic [CW-1:0]       cnt_q, cnt_d;
  logic [CW-1:0]       issue_q, issue_d;
  logic                chk_vld_q, chk_vld_d;
  logic [AW-1:0]       chk_idx_q, chk_idx_d;
  logic [AW-1:0]       hit_q, hit_d;
  ukt_pkg::ukt_cmd_t   op_q, op_d;
  ukt_pkg::ukt_res_t   res_q, res_d;
  logic                valid_q, valid_d;

  logic                mem_we, mem_re;
  logic [AW-1:0]       mem_waddr, mem_raddr;
  ukt_pkg::ukt_entry_t mem_wdata, mem_rdata;
  logic [EW-1:0]       mem_rdata_raw;

  logic [CW-1:0]       last_cnt;
  logic [AW-1:0]       last_idx;
  logic                rd_more;
  logic                hit_now;

  ukt_ram #(
    .WIDTH (EW),
    .DEPTH (DEPTH)
  ) u_entry_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata_raw)
  );

  assign mem_rdata = ukt_pkg::ukt_entry_t'(mem_rdata_raw);
  assign last_cnt  = cnt_q - CW'(1);
  assign last_idx  = last_cnt[AW-1:0];
  assign rd_more   = (issue_q < cnt_q);
  assign hit_now   = chk_vld_q && (mem_rdata.key == op_q.key);
  assign busy      = (state_q != ukt_pkg::S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ukt_pkg::S_IDLE;
      cnt_q     <= '0;
      chk_vld_q <= 1'b0;
      valid_q   <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      chk_vld_q <= chk_vld_d;
      valid_q   <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    issue_q   <= issue_d;
    chk_idx_q <= chk_idx_d;
    hit_q     <= hit_d;
    op_q      <= op_d;
    res_q     <= res_d;
  end

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    issue_d   = issue_q;
    chk_vld_d = 1'b0;
    chk_idx_d = chk_idx_q;
    hit_d     = hit_q;
    op_d      = op_q;
    valid_d   = 1'b0;
    res_d     = '0;
    mem_we    = 1'b0;
    mem_waddr = cnt_q[AW-1:0];
    mem_wdata = '{key: cmd_i.key, data: cmd_i.payload_in};
    mem_re    = 1'b0;
    mem_raddr = issue_q[AW-1:0];

    unique case (state_q)
      ukt_pkg::S_IDLE: begin
        if (start) begin
          op_d = cmd_i;
          unique case (cmd_i.kind)
            ukt_pkg::KIND_INSERT: begin
              valid_d = 1'b1;
              if (cnt_q == CW'(DEPTH)) begin
                res_d.status = ukt_pkg::STAT_FULL;
              end else begin
                mem_we = 1'b1;
                cnt_d  = cnt_q + CW'(1);
              end
            end
            ukt_pkg::KIND_REMOVE, ukt_pkg::KIND_SEARCH: begin
              issue_d = '0;
              state_d = ukt_pkg::S_SCAN;
            end
            default: begin
              valid_d = 1'b1;
            end
          endcase
        end
      end

      ukt_pkg::S_SCAN: begin
        priority if (hit_now) begin
          if (op_q.kind == ukt_pkg::KIND_REMOVE) begin
            // fetch the last entry to move into the hit slot
            mem_re    = 1'b1;
            mem_raddr = last_idx;
            hit_d     = chk_idx_q;
            state_d   = ukt_pkg::S_MOVE;
          end else begin
            valid_d           = 1'b1;
            res_d.position    = ukt_pkg::POS_BITS'(chk_idx_q);
            res_d.payload_out = mem_rdata.data;
            state_d           = ukt_pkg::S_IDLE;
          end
        end else if (!rd_more) begin
          valid_d      = 1'b1;
          res_d.status = ukt_pkg::STAT_NOT_FOUND;
          state_d      = ukt_pkg::S_IDLE;
        end else begin
          mem_re    = 1'b1;
          issue_d   = issue_q + CW'(1);
          chk_vld_d = 1'b1;
          chk_idx_d = issue_q[AW-1:0];
        end
      end

      ukt_pkg::S_MOVE: begin
        mem_we         = 1'b1;
        mem_waddr      = hit_q;
        mem_wdata      = mem_rdata;
        cnt_d          = last_cnt;
        valid_d        = 1'b1;
        res_d.position = ukt_pkg::POS_BITS'(hit_q);
        state_d        = ukt_pkg::S_IDLE;
      end

      default: begin
        state_d = ukt_pkg::S_IDLE;
      end
    endcase

    res_d.entry_count = ukt_pkg::CNT_BITS'(cnt_d);
    res_d.is_empty    = (cnt_d == '0);
    res_d.is_full     = (cnt_d == CW'(DEPTH));
  end

  assign valid_o  = valid_q;
  assign result_o = res_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(DEPTH))
    else $error("entry count above depth");

  a_move_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ukt_pkg::S_MOVE |-> cnt_q != '0)
    else $error("move on an empty table");

  a_chk_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    chk_vld_q |-> (CW'(chk_idx_q) < cnt_q))
    else $error("scan checks an entry past the count");

  a_accept_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> valid_o || busy)
    else $error("accepted word produced neither result nor scan");

  a_full_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && result_o.status == ukt_pkg::STAT_FULL |-> result_o.is_full)
    else $error("full status without full flag");

endmodule

[bench/tb_top.sv]
// Self-checking bench for the unordered key table: directed and random table traffic.
// Predicts every result word from its own copy of the table; needs ukt_pkg and the RTL.
`timescale 1ns / 1ps

module tb_top;

  localparam int TABLE_DEPTH = 16;
  localparam int RANDOM_ITEMS = 1950;
  localparam int DRAIN_CYCLES = TABLE_DEPTH + 12;
  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int POOL_SIZE = 6;

  logic              clk_i;
  logic              rst_ni;
  logic              start;
  logic              busy;
  ukt_pkg::ukt_cmd_t cmd_i;
  logic              valid_o;
  ukt_pkg::ukt_res_t result_o;

  // predicted table contents
  logic [ukt_pkg::KEY_BITS-1:0]  tbl_key[TABLE_DEPTH];
  logic [ukt_pkg::DATA_BITS-1:0] tbl_data[TABLE_DEPTH];
  int                            tbl_fill;

  ukt_pkg::ukt_res_t expected_results[$];
  int       fail_count;
  int       n_insert, n_remove, n_search, n_noop, n_full_hits, n_misses, n_checked;

  unordered_key_table #(.DEPTH(TABLE_DEPTH)) u_top (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .cmd_i    (cmd_i),
    .valid_o  (valid_o),
    .result_o (result_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #10_000_000;
    $display("[unordered_key_table] ERROR");
    $finish;
  end

  // Apply one command to the predicted table and return the result word it yields.
  function automatic ukt_pkg::ukt_res_t apply_table_op(input ukt_pkg::ukt_cmd_t c);
    ukt_pkg::ukt_res_t r;
    int       hit;
    int       i;
    r   = '0;
    hit = -1;
    case (c.kind)
      ukt_pkg::KIND_INSERT: begin
        n_insert++;
        if (tbl_fill >= TABLE_DEPTH) begin
          r.status = ukt_pkg::STAT_FULL;
          n_full_hits++;
        end else begin
          tbl_key[tbl_fill]  = c.key;
          tbl_data[tbl_fill] = c.payload_in;
          tbl_fill++;
        end
      end
      ukt_pkg::KIND_REMOVE, ukt_pkg::KIND_SEARCH: begin
        for (i = 0; i < tbl_fill; i++) begin
          if (hit < 0 && tbl_key[i] == c.key) hit = i;
        end
        if (c.kind == ukt_pkg::KIND_REMOVE) n_remove++;
        else n_search++;
        if (hit < 0) begin
          r.status = ukt_pkg::STAT_NOT_FOUND;
          n_misses++;
        end else begin
          r.position = hit[ukt_pkg::POS_BITS-1:0];
          if (c.kind == ukt_pkg::KIND_SEARCH) begin
            r.payload_out = tbl_data[hit];
          end else begin
            // swap the last entry into the hole
            tbl_key[hit]  = tbl_key[tbl_fill-1];
            tbl_data[hit] = tbl_data[tbl_fill-1];
            tbl_fill--;
          end
        end
      end
      default: n_noop++;
    endcase
    r.entry_count = tbl_fill[ukt_pkg::CNT_BITS-1:0];
    r.is_empty    = (tbl_fill == 0);
    r.is_full     = (tbl_fill >= TABLE_DEPTH);
    return r;
  endfunction

  function automatic int pick_gap(input bit quiet);
    int roll;
    roll = $urandom_range(99);
    if (quiet || roll < 55) return 0;
    if (roll < 90) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  // Present one command word, hold it until accepted, then predict its result.
  task automatic send_word(input ukt_pkg::ukt_cmd_t c, input int gap);
    if (gap > 0) begin
      @(negedge clk_i);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    start <= 1'b1;
    cmd_i <= c;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    expected_results.push_back(apply_table_op(c));
  endtask

  task automatic send_op(input logic [1:0] kind, input logic [ukt_pkg::KEY_BITS-1:0] key,
                         input logic [ukt_pkg::DATA_BITS-1:0] data);
    ukt_pkg::ukt_cmd_t c;
    c.kind       = ukt_pkg::ukt_kind_e'(kind);
    c.key        = key;
    c.payload_in = data;
    send_word(c, pick_gap(1'b0));
  endtask

  // Compare each result word with the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && valid_o) begin
      if (expected_results.size() == 0) begin
        $error("result word with no prediction pending: %h", result_o);
        fail_count++;
      end else begin
        compare_result(result_o, expected_results.pop_front());
      end
    end
  end

  task automatic compare_result(input ukt_pkg::ukt_res_t got, input ukt_pkg::ukt_res_t exp);
    n_checked++;
    if (got.status !== exp.status) begin
      $error("status: expected %0d, got %0d", exp.status, got.status);
      fail_count++;
    end
    if (got.position !== exp.position) begin
      $error("position: expected %0d, got %0d", exp.position, got.position);
      fail_count++;
    end
    if (got.payload_out !== exp.payload_out) begin
      $error("payload_out: expected %h, got %h", exp.payload_out, got.payload_out);
      fail_count++;
    end
    if (got.entry_count !== exp.entry_count) begin
      $error("entry_count: expected %0d, got %0d", exp.entry_count, got.entry_count);
      fail_count++;
    end
    if (got.is_empty !== exp.is_empty) begin
      $error("is_empty: expected %b, got %b", exp.is_empty, got.is_empty);
      fail_count++;
    end
    if (got.is_full !== exp.is_full) begin
      $error("is_full: expected %b, got %b", exp.is_full, got.is_full);
      fail_count++;
    end
  endtask

  task automatic test_empty_table();
    send_op(ukt_pkg::KIND_SEARCH, 16'h0000, 32'h0);
    send_op(ukt_pkg::KIND_REMOVE, 16'hFFFF, 32'hFFFF_FFFF);
    send_op(KIND_UNUSED, 16'hFFFF, 32'hFFFF_FFFF);
  endtask

  // Fill to capacity with extreme and duplicate keys, then overflow.
  task automatic test_fill_and_overflow();
    int i;
    send_op(ukt_pkg::KIND_INSERT, 16'h0000, 32'h0000_0000);
    send_op(ukt_pkg::KIND_INSERT, 16'hFFFF, 32'hFFFF_FFFF);
    send_op(ukt_pkg::KIND_INSERT, 16'h0000, 32'hA5A5_A5A5);
    for (i = 3; i < TABLE_DEPTH; i++) begin
      send_op(ukt_pkg::KIND_INSERT, 16'h1000 + i[ukt_pkg::KEY_BITS-1:0], $urandom);
    end
    send_op(ukt_pkg::KIND_INSERT, 16'h5555, 32'h5555_5555);
    send_op(ukt_pkg::KIND_SEARCH, 16'h0000, 32'h0);
    send_op(ukt_pkg::KIND_SEARCH, 16'h7777, 32'h0);
  endtask

  task automatic test_remove_cases();
    // last entry moves onto itself
    send_op(ukt_pkg::KIND_REMOVE,
            16'h1000 + TABLE_DEPTH[ukt_pkg::KEY_BITS-1:0] - 16'd1, 32'h0);
    send_op(ukt_pkg::KIND_REMOVE, 16'h0000, 32'h0);
    // the duplicate now answers the search
    send_op(ukt_pkg::KIND_SEARCH, 16'h0000, 32'h0);
    send_op(ukt_pkg::KIND_REMOVE, 16'hFFFF, 32'h0);
  endtask

  // Rounds of fill-heavy, drain-heavy and mixed traffic over a small key pool.
  task automatic test_random_traffic();
    logic [ukt_pkg::KEY_BITS-1:0] key_pool[POOL_SIZE];
    ukt_pkg::ukt_cmd_t c;
    logic [31:0] rnd;
    int sent, round_len, mode, roll, ins_pct, rem_pct, i;
    bit quiet;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      for (i = 0; i < POOL_SIZE; i++) begin
        rnd         = $urandom;
        key_pool[i] = rnd[ukt_pkg::KEY_BITS-1:0];
      end
      round_len = $urandom_range(80, 20);
      mode      = $urandom_range(2);
      quiet     = ($urandom_range(3) == 0);
      ins_pct   = (mode == 0) ? 70 : (mode == 1) ? 20 : 40;
      rem_pct   = (mode == 1) ? 55 : 30;
      for (i = 0; i < round_len; i++) begin
        roll = $urandom_range(99);
        if (roll < 3) c.kind = ukt_pkg::ukt_kind_e'(KIND_UNUSED);
        else if (roll < 3 + ins_pct) c.kind = ukt_pkg::KIND_INSERT;
        else if (roll < 3 + ins_pct + rem_pct) c.kind = ukt_pkg::KIND_REMOVE;
        else c.kind = ukt_pkg::KIND_SEARCH;
        roll = $urandom_range(99);
        rnd  = $urandom;
        if (roll < 35 && tbl_fill > 0) c.key = tbl_key[$urandom_range(tbl_fill - 1)];
        else if (roll < 85) c.key = key_pool[$urandom_range(POOL_SIZE - 1)];
        else c.key = rnd[ukt_pkg::KEY_BITS-1:0];
        c.payload_in = $urandom;
        send_word(c, pick_gap(quiet));
        sent++;
      end
    end
  endtask

  initial begin
    rst_ni     = 1'b0;
    start      = 1'b0;
    cmd_i      = '0;
    tbl_fill   = 0;
    fail_count = 0;
    n_insert = 0; n_remove = 0; n_search = 0; n_noop = 0;
    n_full_hits = 0; n_misses = 0; n_checked = 0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_empty_table();
    test_fill_and_overflow();
    test_remove_cases();
    test_random_traffic();

    @(negedge clk_i);
    start <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    // catch any stray result words
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (expected_results.size() != 0) begin
      $error("%0d predicted results never arrived", expected_results.size());
      fail_count++;
    end

    $display("checked %0d results: %0d inserts (%0d on a full table), %0d removes,",
             n_checked, n_insert, n_full_hits, n_remove);
    $display("  %0d searches, %0d key misses, %0d unused commands; %0d failures",
             n_search, n_misses, n_noop, fail_count);
    if (fail_count == 0) begin
      $display("[unordered_key_table] OK");
    end else begin
      $display("[unordered_key_table] ERROR");
    end
    $finish;
  end

endmodule
